### design/bfha_pkg.sv
package bfha_pkg;

  localparam int unsigned HEAP_BYTES = 4096;
  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int unsigned IDX_W      = $clog2(HEAP_WORDS);
  localparam int unsigned SZ_W       = IDX_W + 1;
  localparam int unsigned ENT_W      = SZ_W + 2;
  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned HDR_WORDS  = HDR_BYTES / 4;
  localparam int unsigned ALIGN_MASK = 3;
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned NEED_W     = REQ_W - 1;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ST_W       = 3;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REALLOC = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT   = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_BLK  = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SET_ST,
    OP_SCAN_INIT,
    OP_RD_CUR,
    OP_SCAN_EV,
    OP_SPLIT,
    OP_TAKE,
    OP_RD_OFF,
    OP_CHK_EV,
    OP_KEEP,
    OP_FR_RD,
    OP_NX_ADD,
    OP_CLR_NX,
    OP_FREE_W,
    OP_WALK_EV,
    OP_MERGE,
    OP_CLR_W,
    OP_PUSH
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [ST_W-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [MODE_W-1:0] mode;
    logic              req_zero;
    logic              a_zero;
    logic              range_bad;
    logic              align_bad;
    logic              chk_bad;
    logic              fits;
    logic              scan_last;
    logic              found;
    logic              split_ok;
    logic              nx_merge;
    logic              walk_end;
    logic              walk_hit;
    logic              walk_free;
    logic              walk_zero;
    logic              out_full;
  } sts_t;

  function automatic logic [ENT_W-1:0] mk_ent(input logic [SZ_W-1:0] size, input logic fr);
    return {1'b1, size, fr};
  endfunction

endpackage

### design/bfha_dp.sv
module bfha_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfha_pkg::cmd_t                cmd_i,
  output bfha_pkg::sts_t                sts_o,
  input  logic                          cfg_we_i,
  input  logic [bfha_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic [bfha_pkg::MODE_W-1:0]   mode_i,
  input  logic [bfha_pkg::REQ_W-1:0]    req_i,
  input  logic [bfha_pkg::ADDR_W-1:0]   addr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bfha_pkg::ADDR_W-1:0]   out_addr_o,
  output logic [bfha_pkg::ST_W-1:0]     out_st_o
);

  localparam int unsigned IW = bfha_pkg::IDX_W;
  localparam int unsigned SW = bfha_pkg::SZ_W;
  localparam int unsigned EW = bfha_pkg::ENT_W;
  localparam int unsigned NW = bfha_pkg::NEED_W;
  localparam int unsigned AW = bfha_pkg::ADDR_W;

  logic [EW-1:0] mem_q [bfha_pkg::HEAP_WORDS];
  logic [EW-1:0] rdata_q;
  logic [IW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;
  logic          mem_we;

  logic [IW-1:0]                 clr_q;
  logic [AW-1:0]                 base_q;
  logic [bfha_pkg::MODE_W-1:0]   mode_q;
  logic [bfha_pkg::REQ_W-1:0]    req_q;
  logic [AW-1:0]                 a_q;
  logic [NW-1:0]                 need_q;
  logic [SW-1:0]                 cur_q;
  logic [IW-1:0]                 best_q;
  logic [SW-1:0]                 bsz_q;
  logic                          found_q;
  logic [SW-1:0]                 osz_q;
  logic [IW-1:0]                 w_q;
  logic [SW-1:0]                 s_q;
  logic [AW-1:0]                 res_addr_q;
  logic [bfha_pkg::ST_W-1:0]     st_q;
  logic                          out_valid_q;
  logic [AW-1:0]                 out_addr_q;
  logic [bfha_pkg::ST_W-1:0]     out_st_q;

  logic          rmark, rfree;
  logic [SW-1:0] rsize;
  logic [32:0]   rel33;
  logic [IW+1:0] rel;
  logic [IW-1:0] o_idx;
  logic [SW:0]   scan_sum;
  logic          scan_fit;
  logic [SW-1:0] nx;
  logic [SW:0]   walk_n;
  logic [SW-1:0] rem;
  logic [16:0]   cap;
  logic [16:0]   need_sum;

  assign rmark    = rdata_q[EW-1];
  assign rsize    = rdata_q[SW:1];
  assign rfree    = rdata_q[0];
  assign rel33    = {1'b0, a_q} - {1'b0, base_q};
  assign rel      = rel33[IW+1:0];
  assign o_idx    = rel[IW+1:2] - IW'(bfha_pkg::HDR_WORDS);
  assign scan_sum = {1'b0, cur_q} + {1'b0, rsize};
  assign scan_fit = rfree && (NW'(rsize) >= need_q) && (!found_q || rsize < bsz_q);
  assign nx       = SW'(w_q) + osz_q;
  assign walk_n   = {1'b0, cur_q} + {1'b0, rsize};
  assign rem      = bsz_q - need_q[SW-1:0];
  assign cap      = 17'({osz_q, 2'b00}) - 17'(bfha_pkg::HDR_BYTES);
  assign need_sum = 17'(req_i) + 17'(bfha_pkg::HDR_BYTES + bfha_pkg::ALIGN_MASK);

  always_comb begin
    sts_o.clr_last  = (clr_q == IW'(bfha_pkg::HEAP_WORDS - 1));
    sts_o.mode      = mode_q;
    sts_o.req_zero  = (req_q == '0);
    sts_o.a_zero    = (a_q == '0);
    sts_o.range_bad = rel33[32] || (rel33[31:0] >= 32'(bfha_pkg::HEAP_BYTES));
    sts_o.align_bad = (rel < (IW+2)'(bfha_pkg::HDR_BYTES)) || (rel[1:0] != 2'b00);
    sts_o.chk_bad   = !rmark || rfree;
    sts_o.fits      = (17'(req_q) <= cap);
    sts_o.scan_last = (scan_sum >= (SW+1)'(bfha_pkg::HEAP_WORDS)) || (rsize == '0);
    sts_o.found     = found_q;
    sts_o.split_ok  = (rem >= SW'(bfha_pkg::HDR_WORDS));
    sts_o.nx_merge  = !nx[IW] && rfree;
    sts_o.walk_end  = (cur_q >= SW'(w_q));
    sts_o.walk_hit  = (walk_n == (SW+1)'(w_q));
    sts_o.walk_free = rfree;
    sts_o.walk_zero = (rsize == '0);
    sts_o.out_full  = out_valid_q && !out_ready_i;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (cmd_i.op)
      bfha_pkg::OP_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = (clr_q == '0) ? bfha_pkg::mk_ent(SW'(bfha_pkg::HEAP_WORDS), 1'b1) : '0;
      end
      bfha_pkg::OP_RD_CUR: mem_addr = cur_q[IW-1:0];
      bfha_pkg::OP_SPLIT: begin
        mem_we    = 1'b1;
        mem_addr  = best_q + need_q[IW-1:0];
        mem_wdata = bfha_pkg::mk_ent(rem, 1'b1);
      end
      bfha_pkg::OP_TAKE: begin
        mem_we    = 1'b1;
        mem_addr  = best_q;
        mem_wdata = bfha_pkg::mk_ent(bsz_q, 1'b0);
      end
      bfha_pkg::OP_RD_OFF: mem_addr = o_idx;
      bfha_pkg::OP_FR_RD:  mem_addr = nx[IW-1:0];
      bfha_pkg::OP_CLR_NX: begin
        mem_we   = 1'b1;
        mem_addr = nx[IW-1:0];
      end
      bfha_pkg::OP_FREE_W: begin
        mem_we    = 1'b1;
        mem_addr  = w_q;
        mem_wdata = bfha_pkg::mk_ent(s_q, 1'b1);
      end
      bfha_pkg::OP_MERGE: begin
        mem_we    = 1'b1;
        mem_addr  = cur_q[IW-1:0];
        mem_wdata = bfha_pkg::mk_ent(s_q, 1'b1);
      end
      bfha_pkg::OP_CLR_W: begin
        mem_we   = 1'b1;
        mem_addr = w_q;
      end
      default: mem_addr = cur_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      base_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.op == bfha_pkg::OP_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.op == bfha_pkg::OP_SCAN_INIT) begin
        found_q <= 1'b0;
      end else if (cmd_i.op == bfha_pkg::OP_SCAN_EV && scan_fit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.op == bfha_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bfha_pkg::OP_LOAD: begin
        mode_q     <= mode_i;
        req_q      <= req_i;
        a_q        <= addr_i;
        need_q     <= need_sum[16:2];
        res_addr_q <= '0;
        st_q       <= bfha_pkg::ST_OK;
      end
      bfha_pkg::OP_SET_ST:    st_q  <= cmd_i.st;
      bfha_pkg::OP_SCAN_INIT: cur_q <= '0;
      bfha_pkg::OP_SCAN_EV: begin
        if (scan_fit) begin
          best_q <= cur_q[IW-1:0];
          bsz_q  <= rsize;
        end
        cur_q <= scan_sum[SW-1:0];
      end
      bfha_pkg::OP_SPLIT: bsz_q <= need_q[SW-1:0];
      bfha_pkg::OP_TAKE: begin
        res_addr_q <= base_q + (AW'(best_q) << 2) + AW'(bfha_pkg::HDR_BYTES);
        st_q       <= bfha_pkg::ST_OK;
      end
      bfha_pkg::OP_CHK_EV: begin
        osz_q <= rsize;
        w_q   <= o_idx;
      end
      bfha_pkg::OP_KEEP:   res_addr_q <= a_q;
      bfha_pkg::OP_FR_RD:  s_q <= osz_q;
      bfha_pkg::OP_NX_ADD: s_q <= s_q + rsize;
      bfha_pkg::OP_FREE_W: cur_q <= '0;
      bfha_pkg::OP_WALK_EV: begin
        if (walk_n == (SW+1)'(w_q)) begin
          s_q <= s_q + rsize;
        end else begin
          cur_q <= walk_n[SW-1:0];
        end
      end
      bfha_pkg::OP_PUSH: begin
        out_addr_q <= res_addr_q;
        out_st_q   <= st_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_st_o    = out_st_q;

endmodule

### design/bfha_ctrl.sv
module bfha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfha_pkg::sts_t sts_i,
  output bfha_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_ALLOC, S_SRD, S_SEV, S_AEND, S_ATAKE,
    S_CRD, S_CEV, S_CDEC, S_FRD, S_FEV, S_FCLRNX, S_FWR,
    S_WCHK, S_WRD, S_WEV, S_WMERGE, S_WCLRW, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   grow_q, grow_d;

  always_comb begin
    state_d   = state_q;
    grow_d    = grow_q;
    cmd_o.op  = bfha_pkg::OP_NONE;
    cmd_o.st  = bfha_pkg::ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = bfha_pkg::OP_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bfha_pkg::OP_LOAD;
          grow_d   = 1'b0;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.mode)
          bfha_pkg::MODE_ALLOC:   state_d = S_ALLOC;
          bfha_pkg::MODE_FREE:    state_d = sts_i.a_zero ? S_DONE : S_CRD;
          bfha_pkg::MODE_REALLOC: state_d = sts_i.a_zero ? S_ALLOC : S_CRD;
          default:                state_d = S_DONE;
        endcase
      end
      S_ALLOC: begin
        if (sts_i.req_zero) begin
          cmd_o.op = bfha_pkg::OP_SET_ST;
          cmd_o.st = bfha_pkg::ST_ZERO;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bfha_pkg::OP_SCAN_INIT;
          state_d  = S_SRD;
        end
      end
      S_SRD: begin
        cmd_o.op = bfha_pkg::OP_RD_CUR;
        state_d  = S_SEV;
      end
      S_SEV: begin
        cmd_o.op = bfha_pkg::OP_SCAN_EV;
        state_d  = sts_i.scan_last ? S_AEND : S_SRD;
      end
      S_AEND: begin
        if (!sts_i.found) begin
          cmd_o.op = bfha_pkg::OP_SET_ST;
          cmd_o.st = bfha_pkg::ST_NO_FIT;
          state_d  = S_DONE;
        end else begin
          if (sts_i.split_ok) cmd_o.op = bfha_pkg::OP_SPLIT;
          state_d = S_ATAKE;
        end
      end
      S_ATAKE: begin
        cmd_o.op = bfha_pkg::OP_TAKE;
        state_d  = grow_q ? S_FRD : S_DONE;
      end
      S_CRD: begin
        priority if (sts_i.range_bad) begin
          cmd_o.op = bfha_pkg::OP_SET_ST;
          cmd_o.st = bfha_pkg::ST_RANGE;
          state_d  = S_DONE;
        end else if (sts_i.align_bad) begin
          cmd_o.op = bfha_pkg::OP_SET_ST;
          cmd_o.st = bfha_pkg::ST_BAD_BLK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bfha_pkg::OP_RD_OFF;
          state_d  = S_CEV;
        end
      end
      S_CEV: begin
        if (sts_i.chk_bad) begin
          cmd_o.op = bfha_pkg::OP_SET_ST;
          cmd_o.st = bfha_pkg::ST_BAD_BLK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bfha_pkg::OP_CHK_EV;
          state_d  = S_CDEC;
        end
      end
      S_CDEC: begin
        priority if (sts_i.mode == bfha_pkg::MODE_FREE || sts_i.req_zero) begin
          state_d = S_FRD;
        end else if (sts_i.fits) begin
          cmd_o.op = bfha_pkg::OP_KEEP;
          state_d  = S_DONE;
        end else begin
          grow_d  = 1'b1;
          state_d = S_ALLOC;
        end
      end
      S_FRD: begin
        cmd_o.op = bfha_pkg::OP_FR_RD;
        state_d  = S_FEV;
      end
      S_FEV: begin
        if (sts_i.nx_merge) begin
          cmd_o.op = bfha_pkg::OP_NX_ADD;
          state_d  = S_FCLRNX;
        end else begin
          state_d = S_FWR;
        end
      end
      S_FCLRNX: begin
        cmd_o.op = bfha_pkg::OP_CLR_NX;
        state_d  = S_FWR;
      end
      S_FWR: begin
        cmd_o.op = bfha_pkg::OP_FREE_W;
        state_d  = S_WCHK;
      end
      S_WCHK: state_d = sts_i.walk_end ? S_DONE : S_WRD;
      S_WRD: begin
        cmd_o.op = bfha_pkg::OP_RD_CUR;
        state_d  = S_WEV;
      end
      S_WEV: begin
        priority if (sts_i.walk_zero) begin
          state_d = S_DONE;
        end else if (sts_i.walk_hit) begin
          if (sts_i.walk_free) begin
            cmd_o.op = bfha_pkg::OP_WALK_EV;
            state_d  = S_WMERGE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cmd_o.op = bfha_pkg::OP_WALK_EV;
          state_d  = S_WCHK;
        end
      end
      S_WMERGE: begin
        cmd_o.op = bfha_pkg::OP_MERGE;
        state_d  = S_WCLRW;
      end
      S_WCLRW: begin
        cmd_o.op = bfha_pkg::OP_CLR_W;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.op = bfha_pkg::OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      grow_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grow_q  <= grow_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

### design/best_fit_heap_allocator.sv
// Best-fit heap allocator over a 4 KiB heap of 8-byte-headed blocks.
// Input channel s_axis: tuser carries the mode (allocate, free, reallocate),
// tdata the request size and the payload address. Output channel m_axis
// returns one transaction per input: granted address and status.
// cfg_we_i/cfg_wdata_i set heap_base; write it only while the block is idle.
// After reset the header memory is cleared, one word per cycle, all 1024
// words; s_axis_tready stays low until that pass ends.
// One transaction is processed at a time. Allocate walks every block,
// reading and then evaluating each one on the single-port header memory.
// Free walks the blocks below the freed one for the backward merge walk
// (check, read, evaluate). Reallocate that grows runs both.
// The result sits in an output register; a new transaction is accepted while
// it waits. When the receiver stalls, the next finished result holds until
// the output register drains.
module best_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // request_bytes[15:0], block_address[47:16]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_address[31:0], status[34:32], zero
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  bfha_pkg::cmd_t                cmd;
  bfha_pkg::sts_t                sts;
  logic [bfha_pkg::ADDR_W-1:0]   out_addr;
  logic [bfha_pkg::ST_W-1:0]     out_st;

  bfha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (s_axis_tuser),
    .req_i       (s_axis_tdata[15:0]),
    .addr_i      (s_axis_tdata[47:16]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_addr_o  (out_addr),
    .out_st_o    (out_st)
  );

  assign m_axis_tdata = {5'b0, out_st, out_addr};

  a_st_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34:32] <= bfha_pkg::ST_ZERO))
    else $error("status code out of range");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[34:32] != bfha_pkg::ST_OK) |-> (m_axis_tdata[31:0] == '0))
    else $error("failed transaction returned an address");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a transaction while busy");

endmodule
